/* hdl/dcma_pkg.sv */
// Shared types and codes for the dual-channel moving average block.
// No dependencies; imported by the divider and the top level.
package dcma_pkg;

    // Command codes carried on the input channel.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Probe select codes.
    localparam logic PROBE_ONE = 1'b0;
    localparam logic PROBE_TWO = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_UPDATE = 5'b00100,
        S_DIV    = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    // Status reported by the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* hdl/dcma_ring.sv */
// Sample storage for both channels: two rings sharing one address.
// Depends on nothing outside this file.
module dcma_ring #(
    parameter int DEPTH  = 20,
    parameter int DATA_W = 12,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wr_one,
    input  logic [DATA_W-1:0] wr_two,
    output logic [DATA_W-1:0] rd_one,
    output logic [DATA_W-1:0] rd_two
);

    logic [DATA_W-1:0] mem_one [DEPTH];
    logic [DATA_W-1:0] mem_two [DEPTH];
    logic [DATA_W-1:0] rd_one_reg;
    logic [DATA_W-1:0] rd_two_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_one[addr] <= wr_one;
            mem_two[addr] <= wr_two;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_one_reg <= mem_one[addr];
            rd_two_reg <= mem_two[addr];
        end
    end

    assign rd_one = rd_one_reg;
    assign rd_two = rd_two_reg;

endmodule

/* hdl/dcma_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Depends on dcma_pkg for the status struct.
module dcma_div #(
    parameter int DIVIDEND_W = 17,
    parameter int DIVISOR_W  = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DIVIDEND_W-1:0]   dividend,
    input  logic [DIVISOR_W-1:0]    divisor,
    output dcma_pkg::div_status_t   status,
    output logic [DIVIDEND_W-1:0]   quotient
);

    import dcma_pkg::*;

    localparam int STEP_W = $clog2(DIVIDEND_W);

    logic                  busy_reg, busy_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  den_reg, den_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    den_ext;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // One trial subtraction per cycle.
    assign trial   = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign den_ext = {1'b0, den_reg};
    assign diff    = trial - den_ext;
    assign fits    = (trial >= den_ext);

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIVIDEND_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits DIVISOR_W bits.
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign status.busy = busy_reg;
    assign status.done = busy_reg && (step_reg == '0);
    assign quotient    = quo_reg;

endmodule

/* hdl/dual_channel_moving_average.sv */
// Top level of the dual-channel moving average filter with warm-up.
// Depends on dcma_pkg, dcma_ring and dcma_div.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------
//  input   | in_valid / in_stall  | cmd, sample_one, sample_two, probe
//  output  | out_valid / out_stall| average (one per query)
//
// A sample passes through S_READ (ring read) and S_UPDATE (sum update and ring write).
// A query waits in S_DIV for the serial divider, which produces one quotient
// bit per cycle; an empty window skips the divider and goes straight to S_OUT.
// Reset clears the sums, write position and filled mark; ring contents are
// not cleared and are only used after they have been written.
// The result register holds while out_stall is high; the block keeps taking
// items meanwhile, and a finished query waits until the register is free.
module dual_channel_moving_average #(
    parameter int WINDOW      = 20,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   cmd,
    input  logic [SAMPLE_BITS-1:0] sample_one,
    input  logic [SAMPLE_BITS-1:0] sample_two,
    input  logic                   probe,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SAMPLE_BITS-1:0] average
);

    import dcma_pkg::*;

    localparam int POS_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);
    localparam int EXT_W = SUM_W - SAMPLE_BITS;
    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW * ((1 << SAMPLE_BITS) - 1));

    state_t                 state_reg, state_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   filled_reg, filled_next;
    logic [SUM_W-1:0]       sum_one_reg, sum_one_next;
    logic [SUM_W-1:0]       sum_two_reg, sum_two_next;
    logic [SAMPLE_BITS-1:0] new_one_reg, new_two_reg;
    logic                   empty_reg, empty_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] average_reg, average_next;

    logic                   in_xfer;
    logic                   out_free;
    logic [CNT_W-1:0]       count;
    logic                   div_start;
    logic [SUM_W-1:0]       div_dividend;
    div_status_t            div_status;
    logic [SUM_W-1:0]       div_quotient;
    logic                   ring_wr;
    logic                   ring_rd;
    logic [SAMPLE_BITS-1:0] old_one, old_two;
    logic [SUM_W-1:0]       drop_one, drop_two;

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Valid count: write position during warm-up, the full window after.
    assign count = filled_reg ? CNT_W'(WINDOW) : CNT_W'(pos_reg);

    assign div_start    = in_xfer && (cmd == CMD_QUERY) && (count != '0);
    assign div_dividend = (probe == PROBE_TWO) ? sum_two_reg : sum_one_reg;

    assign ring_rd = (state_reg == S_READ);
    assign ring_wr = (state_reg == S_UPDATE);

    dcma_ring #(
        .DEPTH  (WINDOW),
        .DATA_W (SAMPLE_BITS),
        .ADDR_W (POS_W)
    ) u_ring (
        .clk    (clk),
        .wr_en  (ring_wr),
        .rd_en  (ring_rd),
        .addr   (pos_reg),
        .wr_one (new_one_reg),
        .wr_two (new_two_reg),
        .rd_one (old_one),
        .rd_two (old_two)
    );

    dcma_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // The overwritten reading leaves the sum only once the ring has filled.
    assign drop_one = filled_reg ? {{EXT_W{1'b0}}, old_one} : '0;
    assign drop_two = filled_reg ? {{EXT_W{1'b0}}, old_two} : '0;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        filled_next    = filled_reg;
        sum_one_next   = sum_one_reg;
        sum_two_next   = sum_two_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg;
        average_next   = average_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (cmd == CMD_SAMPLE)
                    begin
                        state_next = S_READ;
                    end
                    else if (count == '0)
                    begin
                        empty_next = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        empty_next = 1'b0;
                        state_next = S_DIV;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                sum_one_next = sum_one_reg - drop_one + {{EXT_W{1'b0}}, new_one_reg};
                sum_two_next = sum_two_reg - drop_two + {{EXT_W{1'b0}}, new_two_reg};
                if (pos_reg == POS_W'(WINDOW - 1))
                begin
                    pos_next    = '0;
                    filled_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
                state_next = S_IDLE;
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Load the result register once it is free.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    average_next   = empty_reg ? '0 : div_quotient[SAMPLE_BITS-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            filled_reg    <= 1'b0;
            sum_one_reg   <= '0;
            sum_two_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            filled_reg    <= filled_next;
            sum_one_reg   <= sum_one_next;
            sum_two_reg   <= sum_two_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer && (cmd == CMD_SAMPLE))
        begin
            new_one_reg <= sample_one;
            new_two_reg <= sample_two;
        end
        empty_reg   <= empty_next;
        average_reg <= average_next;
    end

    assign out_valid = out_valid_reg;
    assign average   = average_reg;

    // The write position always names an entry of the ring.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(WINDOW - 1))
        else $error("write position beyond the ring");

    // A running sum never exceeds a full window of maximum readings.
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_one_reg <= SUM_MAX) && (sum_two_reg <= SUM_MAX))
        else $error("running sum out of range");

    // Once the ring has wrapped it stays filled.
    a_filled_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg |=> filled_reg)
        else $error("filled mark cleared");

    // The divider only runs, and so only finishes, while the sequencer waits for it.
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> (state_reg == S_DIV))
        else $error("divider running outside a query");

endmodule
